### design/psd_pkg.sv
// shared types and constants for the program stream pes demux
// no dependencies
`default_nettype none
package psd_pkg;

	typedef enum logic [4:0] {
		PH_SCAN, PH_LEN_HI, PH_LEN_LO, PH_STUFF, PH_STD_LO, PH_STD_C, PH_TS_BODY,
		PH_M1_DTSMARK, PH_M2_FLAGS, PH_M2_HLEN, PH_M2_PTSMARK, PH_M2_DTSMARK,
		PH_HSKIP, PH_AID, PH_AUDX, PH_LPCM, PH_PAYLOAD, PH_SKIP
	} phase_t;

	typedef enum logic [1:0] {
		TS_FINAL, TS_M1_DTS, TS_M2_DTS, TS_HSKIP
	} ts_next_t;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_HEADER  = 2'd1;
	localparam logic [1:0] KIND_DROP    = 2'd2;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_ZERO_LEN  = 3'd1;
	localparam logic [2:0] ERR_HDR_LONG  = 3'd2;
	localparam logic [2:0] ERR_SUB_SHORT = 3'd3;
	localparam logic [2:0] ERR_BAD_BYTE  = 3'd4;
	localparam logic [2:0] ERR_NO_PAYLD  = 3'd5;

	localparam logic [2:0] CLS_VIDEO   = 3'd0;
	localparam logic [2:0] CLS_MPA     = 3'd1;
	localparam logic [2:0] CLS_PRIV    = 3'd2;
	localparam logic [2:0] CLS_LPCM    = 3'd3;
	localparam logic [2:0] CLS_SUBPIC  = 3'd4;

	localparam logic [1:0] REG_AUDIO    = 2'd0;
	localparam logic [1:0] REG_VIDEO    = 2'd1;
	localparam logic [1:0] REG_SUBTITLE = 2'd2;

	localparam logic [8:0] AUDIO_NONE = 9'd256;
	localparam logic [4:0] VIDEO_NONE = 5'd16;
	localparam logic [5:0] SUB_NONE   = 6'd32;

	localparam logic signed [17:0] SKIP_LIMIT = 18'sd2356;
	localparam int DATA_W = 136;

	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic [7:0]  payload_byte;
		logic        last_byte;
		logic [2:0]  stream_class;
		logic [7:0]  stream_number;
		logic [32:0] pts_ticks;
		logic [32:0] dts_ticks;
		logic        timestamp_fault;
		logic [15:0] payload_length;
		logic [23:0] lpcm_header;
		logic [2:0]  error_code;
	} res_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] index;
		logic [8:0] data;
	} cfg_t;

endpackage
`default_nettype wire

### design/psd_parser.sv
// byte parser: start code hunt, pes header parse, selection, result build
// depends on psd_pkg
`default_nettype none
module psd_parser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    data_byte,
	input  wire psd_pkg::cfg_t cfg,
	output psd_pkg::res_t      res
);
	import psd_pkg::*;

	phase_t            phase_q, phase_n;
	logic [31:0]       scode_q, scode_n;
	logic [1:0]        sync_q, sync_n;
	logic signed [17:0] bleft_q, bleft_n;
	logic [7:0]        hbl_q, hbl_n;
	logic [7:0]        sid_q, sid_n;
	logic [32:0]       pts_q, pts_n, dts_q, dts_n;
	logic [8:0]        lat_a_q, lat_a_n;
	logic [4:0]        lat_v_q, lat_v_n;
	logic [5:0]        ssel_q;
	logic [23:0]       lpcm_q, lpcm_n;
	logic              psel_q, psel_n;
	logic [7:0]        lead_q, lead_n;
	logic [31:0]       word_q, word_n;
	logic [2:0]        cnt_q, cnt_n;
	logic              into_dts_q, into_dts_n;
	ts_next_t          next_q, next_n;
	logic              bad_q, bad_n;
	logic [1:0]        flags_q, flags_n;
	logic [7:0]        sub_q, sub_n;
	logic [2:0]        cls_q, cls_n;
	logic [7:0]        num_q, num_n;
	logic              seen_q, seen_n;

	always_comb begin
		logic [7:0]  b;
		logic [31:0] head;
		logic [32:0] v;
		logic        do_disp, do_tsfin, do_hskip, do_after, do_fin;
		logic [4:0]  n5;
		b = data_byte;
		head = '0;
		v = '0;
		n5 = '0;
		do_disp = 1'b0; do_tsfin = 1'b0; do_hskip = 1'b0; do_after = 1'b0; do_fin = 1'b0;
		phase_n = phase_q; scode_n = scode_q; sync_n = sync_q; bleft_n = bleft_q;
		hbl_n = hbl_q; sid_n = sid_q; pts_n = pts_q; dts_n = dts_q;
		lat_a_n = lat_a_q; lat_v_n = lat_v_q; lpcm_n = lpcm_q; psel_n = psel_q;
		lead_n = lead_q; word_n = word_q; cnt_n = cnt_q; into_dts_n = into_dts_q;
		next_n = next_q; bad_n = bad_q; flags_n = flags_q; sub_n = sub_q;
		cls_n = cls_q; num_n = num_q; seen_n = seen_q;
		res = '0;

		case (phase_q)
			PH_SCAN: begin
				scode_n = {scode_q[23:0], b};
				if (scode_n[31:8] == 24'h000001) begin
					head = scode_n;
					scode_n = '1;
					if (sync_q == 2'd0) begin
						if (head == 32'h1BA) sync_n = 2'd1;
					end else if (sync_q == 2'd1) begin
						if (head == 32'h1BB || head == 32'h1BD
								|| (head >= 32'h1C0 && head <= 32'h1EF))
							sync_n = 2'd2;
						else
							sync_n = 2'd0;
					end
					if (sync_n == 2'd2 && head[7:0] >= 8'hBC && head[7:0] < 8'hF0
							&& head[7:0] != 8'hBE && head[7:0] != 8'hBF) begin
						sid_n = head[7:0];
						pts_n = '0; dts_n = '0; bad_n = 1'b0;
						lpcm_n = '0; seen_n = 1'b0; psel_n = 1'b0;
						cls_n = '0; num_n = '0; hbl_n = '0;
						phase_n = PH_LEN_HI;
					end
				end
			end
			PH_LEN_HI: begin
				bleft_n = 18'(signed'({1'b0, b, 8'h00}));
				phase_n = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				bleft_n = bleft_q | 18'(b);
				if (bleft_n == 18'sd0) begin
					res.valid = 1'b1; res.kind = KIND_DROP; res.error_code = ERR_ZERO_LEN;
					phase_n = PH_SCAN; scode_n = '1;
				end else
					phase_n = PH_STUFF;
			end
			PH_STUFF: begin
				bleft_n = bleft_q - 18'sd1;
				if (b == 8'hFF && bleft_n > 18'sd0) begin
				end else if (b[7:6] == 2'd1)
					phase_n = PH_STD_LO;
				else
					do_disp = 1'b1;
			end
			PH_STD_LO: begin
				bleft_n = bleft_q - 18'sd2;
				phase_n = PH_STD_C;
			end
			PH_STD_C: do_disp = 1'b1;
			PH_TS_BODY: begin
				word_n = {word_q[23:0], b};
				if (cnt_q > 3'd1)
					cnt_n = cnt_q - 3'd1;
				else begin
					cnt_n = '0;
					do_tsfin = 1'b1;
				end
			end
			PH_M1_DTSMARK: begin
				if (b[7:4] != 4'd1) pts_n = '0;
				lead_n = b; word_n = '0; cnt_n = 3'd4; into_dts_n = 1'b1;
				next_n = TS_FINAL; phase_n = PH_TS_BODY;
			end
			PH_M2_FLAGS: begin
				flags_n = b[7:6];
				phase_n = PH_M2_HLEN;
			end
			PH_M2_HLEN: begin
				hbl_n = b;
				bleft_n = bleft_q - 18'sd2;
				if (signed'({10'b0, b}) > bleft_n) begin
					res.valid = 1'b1; res.kind = KIND_DROP; res.error_code = ERR_HDR_LONG;
					phase_n = PH_SCAN; scode_n = '1;
				end else if (flags_q == 2'd2 && b >= 8'd5) begin
					bleft_n = bleft_n - 18'sd5; hbl_n = b - 8'd5;
					next_n = TS_HSKIP; phase_n = PH_M2_PTSMARK;
				end else if (flags_q == 2'd3 && b >= 8'd10) begin
					bleft_n = bleft_n - 18'sd10; hbl_n = b - 8'd10;
					next_n = TS_M2_DTS; phase_n = PH_M2_PTSMARK;
				end else
					do_hskip = 1'b1;
			end
			PH_M2_PTSMARK: begin
				lead_n = b; word_n = '0; cnt_n = 3'd4; into_dts_n = 1'b0;
				phase_n = PH_TS_BODY;
			end
			PH_M2_DTSMARK: begin
				lead_n = b; word_n = '0; cnt_n = 3'd4; into_dts_n = 1'b1;
				next_n = TS_HSKIP; phase_n = PH_TS_BODY;
			end
			PH_HSKIP: begin
				if (hbl_q > 8'd1)
					hbl_n = hbl_q - 8'd1;
				else begin
					hbl_n = '0;
					do_after = 1'b1;
				end
			end
			PH_AID: begin
				sub_n = b;
				bleft_n = bleft_q - 18'sd1;
				if (bleft_n < 18'sd3) begin
					res.valid = 1'b1; res.kind = KIND_DROP; res.error_code = ERR_SUB_SHORT;
					phase_n = PH_SCAN; scode_n = '1;
				end else if (b[7:5] == 3'b001) begin
					if ({1'b0, ssel_q} == {2'b00, b[4:0]}) begin
						psel_n = 1'b1; cls_n = CLS_SUBPIC; num_n = {3'b000, b[4:0]};
					end
					do_fin = 1'b1;
				end else if (b[7:6] == 2'b10 || b[7:5] == 3'b000) begin
					if (lat_a_n == AUDIO_NONE) lat_a_n = {1'b0, b};
					if (lat_a_n == {1'b0, b}) begin
						psel_n = 1'b1;
						cls_n = (b[7:5] == 3'b101) ? CLS_LPCM : CLS_PRIV;
						num_n = b;
						bleft_n = bleft_n - 18'sd3;
						hbl_n = 8'd3;
						phase_n = PH_AUDX;
					end else
						do_fin = 1'b1;
				end else
					do_fin = 1'b1;
			end
			PH_AUDX: begin
				if (hbl_q > 8'd1)
					hbl_n = hbl_q - 8'd1;
				else begin
					hbl_n = '0;
					if (sub_q[7:5] == 3'b101 && bleft_q >= 18'sd3) begin
						bleft_n = bleft_q - 18'sd3;
						hbl_n = 8'd3;
						lpcm_n = '0;
						phase_n = PH_LPCM;
					end else
						do_fin = 1'b1;
				end
			end
			PH_LPCM: begin
				lpcm_n = {lpcm_q[15:0], b};
				if (hbl_q > 8'd1)
					hbl_n = hbl_q - 8'd1;
				else begin
					hbl_n = '0;
					seen_n = 1'b1;
					do_fin = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				bleft_n = bleft_q - 18'sd1;
				res.valid = 1'b1;
				res.kind = KIND_PAYLOAD;
				res.payload_byte = b;
				res.last_byte = (bleft_n <= 18'sd0);
				res.stream_class = cls_q;
				res.stream_number = num_q;
				if (bleft_n <= 18'sd0) begin
					phase_n = PH_SCAN; scode_n = '1;
				end
			end
			PH_SKIP: begin
				bleft_n = bleft_q - 18'sd1;
				if (bleft_n <= 18'sd0) begin
					phase_n = PH_SCAN; scode_n = '1;
				end
			end
			default: begin
				phase_n = PH_SCAN; scode_n = '1;
			end
		endcase

		if (do_disp) begin
			if (b[7:4] == 4'd2) begin
				bleft_n = bleft_n - 18'sd4;
				lead_n = b; word_n = '0; cnt_n = 3'd4; into_dts_n = 1'b0;
				next_n = TS_FINAL; phase_n = PH_TS_BODY;
			end else if (b[7:4] == 4'd3) begin
				bleft_n = bleft_n - 18'sd9;
				lead_n = b; word_n = '0; cnt_n = 3'd4; into_dts_n = 1'b0;
				next_n = TS_M1_DTS; phase_n = PH_TS_BODY;
			end else if (b[7:6] == 2'd2)
				phase_n = PH_M2_FLAGS;
			else if (b == 8'h0F)
				do_fin = 1'b1;
			else begin
				res.valid = 1'b1; res.kind = KIND_DROP; res.error_code = ERR_BAD_BYTE;
				phase_n = PH_SCAN; scode_n = '1;
			end
		end

		if (do_tsfin) begin
			if (lead_q[0] && word_n[16] && word_n[0])
				v = {lead_q[3:1], word_n[31:17], word_n[15:1]};
			else begin
				v = '0;
				bad_n = 1'b1;
			end
			if (into_dts_q) dts_n = v; else pts_n = v;
			case (next_q)
				TS_M1_DTS: phase_n = PH_M1_DTSMARK;
				TS_M2_DTS: phase_n = PH_M2_DTSMARK;
				TS_HSKIP:  do_hskip = 1'b1;
				default:   do_fin = 1'b1;
			endcase
		end

		if (do_hskip) begin
			bleft_n = bleft_n - 18'(hbl_n);
			if (hbl_n > 8'd0)
				phase_n = PH_HSKIP;
			else
				do_after = 1'b1;
		end

		if (do_after) begin
			if (sid_q == 8'hBD)
				phase_n = PH_AID;
			else
				do_fin = 1'b1;
		end

		if (do_fin) begin
			if (bleft_n <= 18'sd0) begin
				res = '0;
				res.valid = 1'b1; res.kind = KIND_DROP; res.error_code = ERR_NO_PAYLD;
				phase_n = PH_SCAN; scode_n = '1;
			end else begin
				n5 = sid_q[4:0];
				if (sid_q >= 8'hC0 && sid_q <= 8'hDF) begin
					if (lat_a_n == AUDIO_NONE) lat_a_n = {4'b0000, n5};
					if (lat_a_n == {4'b0000, n5}) begin
						psel_n = 1'b1; cls_n = CLS_MPA; num_n = {3'b000, n5};
					end
				end else if (sid_q >= 8'hE0 && sid_q <= 8'hEF) begin
					if (lat_v_n == VIDEO_NONE) lat_v_n = {1'b0, n5[3:0]};
					if (lat_v_n == {1'b0, n5[3:0]}) begin
						psel_n = 1'b1; cls_n = CLS_VIDEO; num_n = {4'b0000, n5[3:0]};
					end
				end
				if (psel_n) begin
					res.valid = 1'b1;
					res.kind = KIND_HEADER;
					res.stream_class = cls_n;
					res.stream_number = num_n;
					res.pts_ticks = pts_n;
					res.dts_ticks = dts_n;
					res.timestamp_fault = bad_n;
					res.payload_length = bleft_n[15:0];
					res.lpcm_header = seen_n ? lpcm_n : 24'h0;
					phase_n = PH_PAYLOAD;
				end else if (bleft_n <= SKIP_LIMIT)
					phase_n = PH_SKIP;
				else begin
					phase_n = PH_SCAN; scode_n = '1;
				end
			end
		end
		if (!step) res.valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SCAN; scode_q <= '1; sync_q <= '0; bleft_q <= '0;
			hbl_q <= '0; sid_q <= '0; pts_q <= '0; dts_q <= '0;
			lat_a_q <= AUDIO_NONE; lat_v_q <= VIDEO_NONE; lpcm_q <= '0; psel_q <= 1'b0;
			lead_q <= '0; word_q <= '0; cnt_q <= '0; into_dts_q <= 1'b0;
			next_q <= TS_FINAL; bad_q <= 1'b0; flags_q <= '0; sub_q <= '0;
			cls_q <= '0; num_q <= '0; seen_q <= 1'b0;
			ssel_q <= SUB_NONE;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_AUDIO: lat_a_q <= cfg.data;
				REG_VIDEO: lat_v_q <= cfg.data[4:0];
				REG_SUBTITLE: ssel_q <= cfg.data[5:0];
				default: ;
			endcase
		end else if (step) begin
			phase_q <= phase_n; scode_q <= scode_n; sync_q <= sync_n; bleft_q <= bleft_n;
			hbl_q <= hbl_n; sid_q <= sid_n; pts_q <= pts_n; dts_q <= dts_n;
			lat_a_q <= lat_a_n; lat_v_q <= lat_v_n; lpcm_q <= lpcm_n; psel_q <= psel_n;
			lead_q <= lead_n; word_q <= word_n; cnt_q <= cnt_n; into_dts_q <= into_dts_n;
			next_q <= next_n; bad_q <= bad_n; flags_q <= flags_n; sub_q <= sub_n;
			cls_q <= cls_n; num_q <= num_n; seen_q <= seen_n;
		end
	end

endmodule
`default_nettype wire

### design/program_stream_pes_demux.sv
// program stream pes demux top: input register, parser, result register
// one byte per cycle sustained while m_tready does not stall the result register
// the parser state updates once per byte, paced by the result register
// arst_n clears all control state, selects return to latch-first and no subtitle
// depends on psd_pkg and psd_parser
`default_nettype none
module program_stream_pes_demux (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [7:0]                  s_tdata,   // data_byte
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [psd_pkg::DATA_W-1:0]       m_tdata,   // payload_byte, stream_class,
	                                                    // stream_number, pts_ticks, dts_ticks,
	                                                    // timestamp_fault, payload_length,
	                                                    // lpcm_header, error_code, zero pad
	output logic                             m_tlast,   // last_byte
	output logic [1:0]                       m_tuser,   // event_kind
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [8:0]                  cfg_data
);
	import psd_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       adv;
	res_t       res;
	cfg_t       cfg;

	assign adv = !m_tvalid || m_tready;
	assign s_tready = !vld_s1 || adv;
	// no register write while a byte waits in the input stage
	assign cfg_ready = !vld_s1;
	assign cfg = '{valid: cfg_valid && cfg_ready, index: cfg_index, data: cfg_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (s_tready)
			vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) byte_s1 <= s_tdata;
	end

	psd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (vld_s1 && adv),
		.data_byte (byte_s1),
		.cfg       (cfg),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (adv)
			m_tvalid <= res.valid;
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			m_tdata <= {7'b0, res.error_code, res.lpcm_header, res.payload_length,
				res.timestamp_fault, res.dts_ticks, res.pts_ticks, res.stream_number,
				res.stream_class, res.payload_byte};
			m_tlast <= res.last_byte;
			m_tuser <= res.kind;
		end
	end

	a_last_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == KIND_PAYLOAD)
		else $error("last marked on non-payload transaction");

	a_drop_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_DROP |-> m_tdata[128:126] != ERR_NONE)
		else $error("drop without error code");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> s_tready)
		else $error("input stalled with empty stage");

endmodule
`default_nettype wire

### tb/tb_top.sv
// testbench for program_stream_pes_demux: builds program streams of pes packets,
// predicts the event stream in a local model and checks every output transaction
// depends on psd_pkg and program_stream_pes_demux
`default_nettype none
module tb_top;
	import psd_pkg::*;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  pbyte;
		logic        last;
		logic [2:0]  cls;
		logic [7:0]  num;
		logic [32:0] pts;
		logic [32:0] dts;
		logic        tsf;
		logic [15:0] plen;
		logic [23:0] lpcm;
		logic [2:0]  err;
	} demux_event_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [DATA_W-1:0]  m_tdata;
	logic               m_tlast;
	logic [1:0]         m_tuser;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [8:0]         cfg_data = '0;

	program_stream_pes_demux dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	int errors = 0;
	int bytes_sent = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int stall_cycles = 0;
	demux_event_t expected_events[$];
	logic [7:0] stream_q[$];
	logic [7:0] body_q[$];

	// demux model state
	int          want_sub;
	logic [31:0] sc_window;
	int          sync_lvl;
	phase_t      phase;
	int          left;
	int          hdr_left;
	logic [7:0]  cur_id;
	logic [32:0] pts_acc, dts_acc;
	int          lat_audio, lat_video;
	logic [23:0] lpcm_cap;
	bit          pkt_sel;
	logic [7:0]  ts_lead;
	logic [31:0] ts_word;
	int          ts_cnt;
	bit          ts_to_dts;
	ts_next_t    ts_nxt;
	bit          ts_bad;
	logic [1:0]  pes_flags;
	logic [7:0]  sub_id;
	logic [2:0]  sel_cls;
	logic [7:0]  sel_num;
	bit          lpcm_seen;

	function automatic void model_reset();
		want_sub = SUB_NONE;
		sc_window = '1; sync_lvl = 0; phase = PH_SCAN; left = 0; hdr_left = 0;
		cur_id = '0; pts_acc = '0; dts_acc = '0; lat_audio = AUDIO_NONE;
		lat_video = VIDEO_NONE; lpcm_cap = '0; pkt_sel = 0; ts_lead = '0;
		ts_word = '0; ts_cnt = 0; ts_to_dts = 0; ts_nxt = TS_FINAL; ts_bad = 0;
		pes_flags = '0; sub_id = '0; sel_cls = '0; sel_num = '0; lpcm_seen = 0;
	endfunction

	function automatic void go_scan();
		phase = PH_SCAN;
		sc_window = '1;
	endfunction

	function automatic bit drop_pkt(output demux_event_t ev, input logic [2:0] code);
		ev = '0;
		ev.kind = KIND_DROP;
		ev.err = code;
		go_scan();
		return 1;
	endfunction

	function automatic bit finalize_hdr(output demux_event_t ev);
		int n;
		ev = '0;
		if (left <= 0)
			return drop_pkt(ev, ERR_NO_PAYLD);
		if (cur_id >= 8'hC0 && cur_id <= 8'hDF) begin
			n = cur_id - 8'hC0;
			if (lat_audio == AUDIO_NONE) lat_audio = n;
			if (lat_audio == n) begin
				pkt_sel = 1; sel_cls = CLS_MPA; sel_num = 8'(n);
			end
		end else if (cur_id >= 8'hE0 && cur_id <= 8'hEF) begin
			n = cur_id - 8'hE0;
			if (lat_video == VIDEO_NONE) lat_video = n;
			if (lat_video == n) begin
				pkt_sel = 1; sel_cls = CLS_VIDEO; sel_num = 8'(n);
			end
		end
		if (pkt_sel) begin
			ev.kind = KIND_HEADER;
			ev.cls = sel_cls;
			ev.num = sel_num;
			ev.pts = pts_acc;
			ev.dts = dts_acc;
			ev.tsf = ts_bad;
			ev.plen = left[15:0];
			ev.lpcm = lpcm_seen ? lpcm_cap : 24'd0;
			phase = PH_PAYLOAD;
			return 1;
		end
		if (left <= SKIP_LIMIT) phase = PH_SKIP;
		else go_scan();
		return 0;
	endfunction

	function automatic bit after_m2_hdr(output demux_event_t ev);
		ev = '0;
		if (cur_id == 8'hBD) begin
			phase = PH_AID;
			return 0;
		end
		return finalize_hdr(ev);
	endfunction

	function automatic bit skip_hdr(output demux_event_t ev);
		ev = '0;
		left -= hdr_left;
		if (hdr_left > 0) begin
			phase = PH_HSKIP;
			return 0;
		end
		return after_m2_hdr(ev);
	endfunction

	function automatic void ts_start(logic [7:0] lead, bit to_dts, ts_next_t nxt);
		ts_lead = lead; ts_word = '0; ts_cnt = 4; ts_to_dts = to_dts;
		ts_nxt = nxt; phase = PH_TS_BODY;
	endfunction

	function automatic bit ts_done(output demux_event_t ev);
		logic [15:0] d, e;
		logic [32:0] v;
		ev = '0;
		d = ts_word[31:16];
		e = ts_word[15:0];
		v = '0;
		if (ts_lead[0] && d[0] && e[0]) v = {ts_lead[3:1], d[15:1], e[15:1]};
		else ts_bad = 1;
		if (ts_to_dts) dts_acc = v;
		else pts_acc = v;
		case (ts_nxt)
			TS_M1_DTS: begin
				phase = PH_M1_DTSMARK;
				return 0;
			end
			TS_M2_DTS: begin
				phase = PH_M2_DTSMARK;
				return 0;
			end
			TS_HSKIP: return skip_hdr(ev);
			default: return finalize_hdr(ev);
		endcase
	endfunction

	function automatic bit dispatch_hdr(output demux_event_t ev, input logic [7:0] c);
		ev = '0;
		if (c[7:4] == 4'h2) begin
			left -= 4; ts_start(c, 0, TS_FINAL); return 0;
		end
		if (c[7:4] == 4'h3) begin
			left -= 9; ts_start(c, 0, TS_M1_DTS); return 0;
		end
		if (c[7:6] == 2'b10) begin
			phase = PH_M2_FLAGS; return 0;
		end
		if (c == 8'h0F) return finalize_hdr(ev);
		return drop_pkt(ev, ERR_BAD_BYTE);
	endfunction

	function automatic bit substream_id(output demux_event_t ev, input logic [7:0] b);
		ev = '0;
		sub_id = b;
		left -= 1;
		if (left < 3) return drop_pkt(ev, ERR_SUB_SHORT);
		if (b[7:5] == 3'b001) begin
			if (want_sub == b[4:0]) begin
				pkt_sel = 1; sel_cls = CLS_SUBPIC; sel_num = {3'b000, b[4:0]};
			end
			return finalize_hdr(ev);
		end
		if (b[7:6] == 2'b10 || b[7:5] == 3'b000) begin
			if (lat_audio == AUDIO_NONE) lat_audio = b;
			if (lat_audio == b) begin
				pkt_sel = 1;
				sel_cls = (b[7:5] == 3'b101) ? CLS_LPCM : CLS_PRIV;
				sel_num = b;
				left -= 3;
				hdr_left = 3;
				phase = PH_AUDX;
				return 0;
			end
		end
		return finalize_hdr(ev);
	endfunction

	function automatic void scan_byte(logic [7:0] b);
		logic [31:0] head;
		logic [7:0] id;
		sc_window = {sc_window[23:0], b};
		if ((sc_window & 32'hFFFFFF00) != 32'h100) return;
		head = sc_window;
		sc_window = '1;
		if (sync_lvl == 0) begin
			if (head == 32'h1BA) sync_lvl = 1;
		end else if (sync_lvl == 1) begin
			if (head == 32'h1BB || head == 32'h1BD || (head >= 32'h1C0 && head <= 32'h1EF))
				sync_lvl = 2;
			else
				sync_lvl = 0;
		end
		if (sync_lvl < 2) return;
		id = head[7:0];
		if (id < 8'hBC || id >= 8'hF0 || id == 8'hBE || id == 8'hBF) return;
		cur_id = id;
		pts_acc = '0; dts_acc = '0; ts_bad = 0; lpcm_cap = '0; lpcm_seen = 0;
		pkt_sel = 0; sel_cls = '0; sel_num = '0; hdr_left = 0;
		phase = PH_LEN_HI;
	endfunction

	function automatic bit demux_predict(output demux_event_t ev, input logic [7:0] b);
		ev = '0;
		case (phase)
			PH_SCAN: begin
				scan_byte(b);
				return 0;
			end
			PH_LEN_HI: begin
				left = b << 8;
				phase = PH_LEN_LO;
				return 0;
			end
			PH_LEN_LO: begin
				left = left | b;
				if (left == 0) return drop_pkt(ev, ERR_ZERO_LEN);
				phase = PH_STUFF;
				return 0;
			end
			PH_STUFF: begin
				left -= 1;
				if (b == 8'hFF && left > 0) return 0;
				if (b[7:6] == 2'b01) begin
					phase = PH_STD_LO;
					return 0;
				end
				return dispatch_hdr(ev, b);
			end
			PH_STD_LO: begin
				left -= 2;
				phase = PH_STD_C;
				return 0;
			end
			PH_STD_C: return dispatch_hdr(ev, b);
			PH_TS_BODY: begin
				ts_word = {ts_word[23:0], b};
				if (ts_cnt > 1) begin
					ts_cnt--;
					return 0;
				end
				ts_cnt = 0;
				return ts_done(ev);
			end
			PH_M1_DTSMARK: begin
				if (b[7:4] != 4'h1) pts_acc = '0;
				ts_start(b, 1, TS_FINAL);
				return 0;
			end
			PH_M2_FLAGS: begin
				pes_flags = b[7:6];
				phase = PH_M2_HLEN;
				return 0;
			end
			PH_M2_HLEN: begin
				hdr_left = b;
				left -= 2;
				if (hdr_left > left) return drop_pkt(ev, ERR_HDR_LONG);
				if (pes_flags == 2'd2 && hdr_left >= 5) begin
					left -= 5; hdr_left -= 5;
					ts_nxt = TS_HSKIP; phase = PH_M2_PTSMARK;
					return 0;
				end
				if (pes_flags == 2'd3 && hdr_left >= 10) begin
					left -= 10; hdr_left -= 10;
					ts_nxt = TS_M2_DTS; phase = PH_M2_PTSMARK;
					return 0;
				end
				return skip_hdr(ev);
			end
			PH_M2_PTSMARK: begin
				ts_start(b, 0, ts_nxt);
				return 0;
			end
			PH_M2_DTSMARK: begin
				ts_start(b, 1, TS_HSKIP);
				return 0;
			end
			PH_HSKIP: begin
				if (hdr_left > 1) begin
					hdr_left--;
					return 0;
				end
				hdr_left = 0;
				return after_m2_hdr(ev);
			end
			PH_AID: return substream_id(ev, b);
			PH_AUDX: begin
				if (hdr_left > 1) begin
					hdr_left--;
					return 0;
				end
				hdr_left = 0;
				if (sub_id[7:5] == 3'b101 && left >= 3) begin
					left -= 3; hdr_left = 3; lpcm_cap = '0;
					phase = PH_LPCM;
					return 0;
				end
				return finalize_hdr(ev);
			end
			PH_LPCM: begin
				lpcm_cap = {lpcm_cap[15:0], b};
				if (hdr_left > 1) begin
					hdr_left--;
					return 0;
				end
				hdr_left = 0;
				lpcm_seen = 1;
				return finalize_hdr(ev);
			end
			PH_PAYLOAD: begin
				left -= 1;
				ev.kind = KIND_PAYLOAD;
				ev.pbyte = b;
				ev.last = (left <= 0);
				ev.cls = sel_cls;
				ev.num = sel_num;
				if (left <= 0) go_scan();
				return 1;
			end
			PH_SKIP: begin
				left -= 1;
				if (left <= 0) go_scan();
				return 0;
			end
			default: begin
				go_scan();
				return 0;
			end
		endcase
	endfunction

	task automatic report(string field, logic [32:0] got, logic [32:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
	endtask

	task automatic check_field(string field, logic [32:0] got, logic [32:0] want);
		if (got !== want) report(field, got, want);
	endtask

	// result checker
	always @(posedge clk) begin
		demux_event_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata[7:0], m_tlast, m_tdata[10:8], m_tdata[18:11],
				m_tdata[51:19], m_tdata[84:52], m_tdata[85], m_tdata[101:86],
				m_tdata[125:102], m_tdata[128:126]};
			if (expected_events.size() == 0) begin
				report("unexpected transaction", got.kind, '0);
			end else begin
				want = expected_events.pop_front();
				check_field("event_kind", got.kind, want.kind);
				check_field("payload_byte", got.pbyte, want.pbyte);
				check_field("last_byte", got.last, want.last);
				check_field("stream_class", got.cls, want.cls);
				check_field("stream_number", got.num, want.num);
				check_field("pts_ticks", got.pts, want.pts);
				check_field("dts_ticks", got.dts, want.dts);
				check_field("timestamp_fault", got.tsf, want.tsf);
				check_field("payload_length", got.plen, want.plen);
				check_field("lpcm_header", got.lpcm, want.lpcm);
				check_field("error_code", got.err, want.err);
			end
		end
	end

	// receiver ready, with random stalls and long hold-offs
	always @(posedge clk) begin
		if (stall_cycles > 0) begin
			m_tready <= 1'b0;
			stall_cycles--;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	task automatic send_byte(logic [7:0] b);
		demux_event_t ev;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
		if (demux_predict(ev, b)) expected_events.push_back(ev);
	endtask

	task automatic send_stream();
		foreach (stream_q[i]) send_byte(stream_q[i]);
		stream_q.delete();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_events.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [8:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_AUDIO: lat_audio = val;
			REG_VIDEO: lat_video = val[4:0];
			REG_SUBTITLE: want_sub = val[5:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_selects(int a, int v, int s);
		wait_drained();
		cfg_write(REG_AUDIO, 9'(a));
		cfg_write(REG_VIDEO, 9'(v));
		cfg_write(REG_SUBTITLE, 9'(s));
	endtask

	function automatic void push_start(logic [7:0] id);
		stream_q.push_back(8'h00);
		stream_q.push_back(8'h00);
		stream_q.push_back(8'h01);
		stream_q.push_back(id);
	endfunction

	function automatic void push_pack();
		push_start(8'hBA);
		stream_q.push_back(8'h44);
		repeat (8) stream_q.push_back(8'($urandom_range(2, 255)));
		stream_q.push_back(8'hF8);
	endfunction

	function automatic void push_ts(logic [3:0] pfx, bit bad);
		logic [32:0] v;
		logic [7:0] t[5];
		int k;
		v = {1'($urandom_range(1)), 32'($urandom())};
		t[0] = {pfx, v[32:30], 1'b1};
		t[1] = v[29:22];
		t[2] = {v[21:15], 1'b1};
		t[3] = v[14:7];
		t[4] = {v[6:0], 1'b1};
		if (bad) begin
			k = 2 * $urandom_range(2);
			t[k][0] = 1'b0;
		end
		foreach (t[i]) body_q.push_back(t[i]);
	endfunction

	// tsm: 0 none, 1 pts, 2 pts and dts; sub < 0 means no substream byte
	function automatic void push_pes(logic [7:0] id, bit m2, int tsm, int npay, int adj,
			bit bad, int sub);
		int stuff, len;
		body_q.delete();
		if (m2) begin
			stuff = $urandom_range(2);
			body_q.push_back(8'h80 | 8'($urandom_range(63)));
			body_q.push_back({(tsm == 0) ? 2'd0 : (tsm == 1) ? 2'd2 : 2'd3,
				6'($urandom_range(63))});
			body_q.push_back(8'((tsm == 1 ? 5 : tsm == 2 ? 10 : 0) + stuff));
			if (tsm != 0) push_ts((tsm == 2) ? 4'h3 : 4'h2, bad);
			if (tsm == 2) push_ts(4'h1, 0);
			repeat (stuff) body_q.push_back(8'hFF);
		end else begin
			repeat ($urandom_range(2)) body_q.push_back(8'hFF);
			if ($urandom_range(1)) begin
				body_q.push_back(8'h40 | 8'($urandom_range(63)));
				body_q.push_back(8'($urandom()));
			end
			if (tsm == 0) body_q.push_back(8'h0F);
			else if (tsm == 1) push_ts(4'h2, bad);
			else begin
				push_ts(4'h3, bad);
				push_ts(($urandom_range(7) == 0) ? 4'h2 : 4'h1, 0);
			end
		end
		if (sub >= 0) begin
			body_q.push_back(8'(sub));
			if (sub[7:6] == 2'b10 || sub < 8'h20)
				repeat (3) body_q.push_back(8'($urandom()));
			if (sub[7:5] == 3'b101)
				repeat (3) body_q.push_back(8'($urandom()));
		end
		repeat (npay) body_q.push_back(8'($urandom()));
		len = body_q.size() + adj;
		if (len < 0) len = 0;
		push_start(id);
		stream_q.push_back(len[15:8]);
		stream_q.push_back(len[7:0]);
		foreach (body_q[i]) stream_q.push_back(body_q[i]);
	endfunction

	task automatic test_directed();
		set_selects(AUDIO_NONE, VIDEO_NONE, 0);
		push_pack();
		push_pes(8'hE0, 0, 1, 4, 0, 0, -1);
		push_pes(8'hE0, 0, 2, 3, 0, 0, -1);
		push_pes(8'hE0, 0, 2, 2, 0, 1, -1);
		push_pes(8'hE0, 0, 0, 1, 0, 0, -1);
		push_pes(8'hE0, 1, 1, 5, 0, 0, -1);
		push_pes(8'hE0, 1, 2, 3, 0, 1, -1);
		push_pes(8'hC3, 1, 1, 3, 0, 0, -1);
		push_pes(8'hBD, 1, 0, 3, 0, 0, 8'h20);
		push_pes(8'hBD, 1, 0, 4, 0, 0, 8'h80);
		push_pes(8'hE1, 1, 0, 3, 0, 0, -1);
		push_start(8'hBE);
		push_start(8'hBF);
		push_start(8'hF3);
		push_start(8'hE0);
		stream_q.push_back(8'h00);
		stream_q.push_back(8'h00);
		push_start(8'hE0);
		stream_q.push_back(8'h00);
		stream_q.push_back(8'h05);
		stream_q.push_back(8'hC5);
		push_pes(8'hE0, 1, 2, 0, -8, 0, -1);
		push_pes(8'hBD, 1, 0, 0, -3, 0, 8'h81);
		push_pes(8'hE0, 0, 0, 0, 0, 0, -1);
		push_pes(8'hE0, 0, 1, 2, -5, 0, -1);
		send_stream();
		set_selects(8'hA0, 0, SUB_NONE);
		push_pes(8'hBD, 1, 1, 4, 0, 0, 8'hA0);
		push_pes(8'hBD, 1, 0, 3, 0, 0, 8'h00);
		// unselected packet declared far longer than sent, the rest is scanned
		push_pes(8'hE7, 1, 0, 2, 2498, 0, -1);
		push_pes(8'hE0, 1, 0, 2, 0, 0, -1);
		send_stream();
	endtask

	function automatic logic [7:0] pick_id();
		case ($urandom_range(9))
			0, 1, 2: return 8'hE0 + 8'($urandom_range(2));
			3, 4:    return 8'hC0 + 8'($urandom_range(1));
			5, 6:    return 8'hBD;
			7:       return ($urandom_range(1)) ? 8'hBC : 8'hBE;
			8:       return 8'($urandom());
			default: return 8'hF0 + 8'($urandom_range(15));
		endcase
	endfunction

	function automatic int pick_sub();
		case ($urandom_range(5))
			0: return 8'h80 + $urandom_range(3);
			1: return 8'hA0 + $urandom_range(1);
			2: return 8'h20 + $urandom_range(1);
			3: return $urandom_range(1);
			4: return 8'h1F;
			default: return $urandom_range(255);
		endcase
	endfunction

	task automatic test_random_mix(int target);
		logic [7:0] id;
		int r;
		target += bytes_sent;
		while (bytes_sent < target) begin
			r = $urandom_range(99);
			if (r < 8) begin
				repeat ($urandom_range(1, 8)) stream_q.push_back(8'($urandom()));
			end else if (r < 12) begin
				push_pack();
			end else begin
				id = pick_id();
				push_pes(id, (id == 8'hBD) ? ($urandom_range(7) != 0) : $urandom_range(1),
					$urandom_range(2), ($urandom_range(9) == 0) ? 0 : $urandom_range(24),
					($urandom_range(9) < 8) ? 0 : $urandom_range(7) - 4,
					($urandom_range(9) == 0), (id == 8'hBD) ? pick_sub() : -1);
			end
			send_stream();
		end
	endtask

	task automatic test_backpressure();
		stall_cycles = 400;
		repeat (6) push_pes(8'hE0, 1, 1, 20, 0, 0, -1);
		send_stream();
	endtask

	initial begin
		model_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle_pct = 19;
		snk_idle_pct = 63;
		test_directed();
		test_random_mix(250);
		set_selects(0, 15, 31);
		src_idle_pct = 63;
		snk_idle_pct = 19;
		test_random_mix(250);
		set_selects(511, 31, 63);
		test_random_mix(100);
		set_selects(1, 1, 1);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_mix(200);
		test_backpressure();
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire
